// ===== rtl/vidx_pkg.sv =====
`timescale 1ns / 1ps

package vidx_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int INDEX_WIDTH_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int VID_W           = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } scan_state_t;

  typedef struct packed {
    logic [VID_W-1:0]   vertex_id;
    logic               is_new;
    logic [FIELD_W-1:0] new_pos;
    logic [FIELD_W-1:0] new_tex;
    logic [FIELD_W-1:0] new_normal;
    logic               overflow;
    logic               group_end;
  } res_t;

endpackage

// ===== rtl/vertex_index_deduplicator_unit.sv =====
// Items are searched one at a time: a new item is accepted only once the result of the last
//   one has been handed to the output register. The search is a linear scan of the key RAM at
//   one entry per cycle through its single read port, over the triples stored in the group.
// The output register lets the next item be accepted while a result is still stalled.
// Reset (synchronous, rst_n low): FSM idle, table count zero, output invalid;
//   key RAM contents are not cleared and are never read before written.
`timescale 1ns / 1ps

module vertex_index_deduplicator_unit #(
  parameter int TABLE_DEPTH = vidx_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_WIDTH = vidx_pkg::INDEX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vidx_pkg::FIELD_W-1:0]  in_pos_index,
  input  logic [vidx_pkg::FIELD_W-1:0]  in_tex_index,
  input  logic [vidx_pkg::FIELD_W-1:0]  in_normal_index,
  input  logic                          in_group_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vidx_pkg::VID_W-1:0]    out_vertex_id,
  output logic                          out_is_new,
  output logic [vidx_pkg::FIELD_W-1:0]  out_new_pos,
  output logic [vidx_pkg::FIELD_W-1:0]  out_new_tex,
  output logic [vidx_pkg::FIELD_W-1:0]  out_new_normal,
  output logic                          out_overflow,
  output logic                          out_group_end
);

  import vidx_pkg::*;

  localparam int KW = 3 * INDEX_WIDTH;

  logic [INDEX_WIDTH-1:0] pos_m, tex_m, nrm_m;
  logic [KW-1:0]          key;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;
  logic                   out_valid_r;
  res_t                   out_r;

  assign pos_m = INDEX_WIDTH'({{INDEX_WIDTH{1'b0}}, in_pos_index});
  assign tex_m = INDEX_WIDTH'({{INDEX_WIDTH{1'b0}}, in_tex_index});
  assign nrm_m = INDEX_WIDTH'({{INDEX_WIDTH{1'b0}}, in_normal_index});
  assign key   = {nrm_m, tex_m, pos_m};

  vidx_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_stall (in_stall),
    .item_key   (key),
    .item_last  (in_group_last),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vertex_id  = out_r.vertex_id;
  assign out_is_new     = out_r.is_new;
  assign out_new_pos    = out_r.new_pos;
  assign out_new_tex    = out_r.new_tex;
  assign out_new_normal = out_r.new_normal;
  assign out_overflow   = out_r.overflow;
  assign out_group_end  = out_r.group_end;

endmodule

// ===== rtl/vidx_key_ram.sv =====
`timescale 1ns / 1ps

module vidx_key_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/vidx_scan.sv =====
`timescale 1ns / 1ps

module vidx_scan #(
  parameter int TABLE_DEPTH = vidx_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_WIDTH = vidx_pkg::INDEX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [3*INDEX_WIDTH-1:0]   item_key,
  input  logic                       item_last,
  output logic                       res_valid,
  input  logic                       res_ready,
  output vidx_pkg::res_t             res
);

  import vidx_pkg::*;

  localparam int KW = 3 * INDEX_WIDTH;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  scan_state_t     state_r, state_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic            last_r, last_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic            found_r, found_nxt;
  logic [CW-1:0]   hit_idx_r, hit_idx_nxt;

  logic            rd_en;
  logic [KW-1:0]   rd_data;
  logic            wr_en;
  logic            match_now;
  logic            full;
  logic [CW-1:0]   id;

  vidx_key_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_en     = (state_r == S_SCAN) && (rd_idx_r != count_r);
  assign match_now = cmp_vld_r && (rd_data == key_r);
  assign full      = (count_r == CW'(TABLE_DEPTH));
  assign wr_en     = (state_r == S_RESP) && res_ready && !found_r && !full;

  assign item_stall = (state_r != S_IDLE);
  assign res_valid  = (state_r == S_RESP);

  always_comb begin
    if (found_r) begin
      id = hit_idx_r;
    end else if (!full) begin
      id = count_r;
    end else begin
      id = '0;
    end
    res.vertex_id  = VID_W'(id);
    res.is_new     = !found_r && !full;
    res.overflow   = !found_r && full;
    res.group_end  = last_r;
    res.new_pos    = res.is_new ? FIELD_W'(key_r[INDEX_WIDTH-1:0]) : '0;
    res.new_tex    = res.is_new ? FIELD_W'(key_r[2*INDEX_WIDTH-1:INDEX_WIDTH]) : '0;
    res.new_normal = res.is_new ? FIELD_W'(key_r[3*INDEX_WIDTH-1:2*INDEX_WIDTH]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    last_r    <= last_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    found_r   <= found_nxt;
    hit_idx_r <= hit_idx_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    last_nxt    = last_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    found_nxt   = found_r;
    hit_idx_nxt = hit_idx_r;
    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          key_nxt    = item_key;
          last_nxt   = item_last;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_vld_nxt = rd_en;
        cmp_idx_nxt = rd_idx_r;
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (match_now) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_RESP;
        end else if (!rd_en) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          if (last_r) begin
            count_nxt = '0;
          end else if (wr_en) begin
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/vidx_checker.sv =====
`timescale 1ns / 1ps

module vidx_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [vidx_pkg::VID_W-1:0]    out_vertex_id,
  input logic                          out_is_new,
  input logic [vidx_pkg::FIELD_W-1:0]  out_new_pos,
  input logic [vidx_pkg::FIELD_W-1:0]  out_new_tex,
  input logic [vidx_pkg::FIELD_W-1:0]  out_new_normal,
  input logic                          out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_in_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken during a search");

  a_new_vs_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_overflow))
    else $error("item both new and overflowed");

  a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_new |->
      out_new_pos == '0 && out_new_tex == '0 && out_new_normal == '0)
    else $error("echo fields nonzero for an old triple");

  a_ovf_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_vertex_id == '0)
    else $error("overflow with nonzero vertex id");

endmodule

bind vertex_index_deduplicator_unit vidx_checker u_vidx_checker (.*);
